[rtl/jslm_pkg.sv]
package jslm_pkg;

  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;
  localparam int DataW   = 32;
  localparam int SpdW    = 17;
  localparam int YW      = 27;
  localparam int NumW    = 35;
  localparam int QW      = 37;
  localparam int MagW    = 36;
  localparam int ProdW   = MagW + SpdW;
  localparam int HalfW   = 18;
  localparam int D10W    = 22;

  localparam logic [CfgIdxW-1:0] RegStepsPerRev = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGearRatio   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLimitMin    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLimitMax    = 2'd3;

  localparam logic [CfgW-1:0] StepsPerRevRst = 16'd3200;
  localparam logic [CfgW-1:0] GearRatioRst   = 16'd100;
  localparam logic [CfgW-1:0] GearDefault    = 16'd100;
  localparam logic [CfgW-1:0] LimitMinRst    = 16'hF8F8;
  localparam logic [CfgW-1:0] LimitMaxRst    = 16'd1800;

  // 36000 = 32 * 1125, the 1125 part by reciprocal with one correction
  localparam logic [27:0]   SpdRecip   = 28'd244335917;
  localparam int            SpdShift   = 38;
  localparam logic [10:0]   SpdDivisor = 11'd1125;
  localparam logic [SpdW-1:0] SpdMax   = 17'd119301;

  localparam logic [D10W-1:0] Div10Recip = 22'd3355443;
  localparam int              Div10Shift = 25;

  function automatic logic [D10W-1:0] div10(input logic [D10W-1:0] x);
    logic [2*D10W-1:0] p;
    logic [D10W-1:0]   q0;
    logic [D10W-1:0]   r;
    p  = (2*D10W)'(x) * (2*D10W)'(Div10Recip);
    q0 = D10W'(p[2*D10W-1:Div10Shift]);
    r  = x - D10W'(q0 * D10W'(10));
    return q0 + D10W'(r >= D10W'(10));
  endfunction

endpackage

[rtl/jslm_if.sv]
interface jslm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [jslm_pkg::DataW-1:0]   current_position;
  logic signed [jslm_pkg::DataW-1:0]   req_delta;
  modport source (output valid, current_position, req_delta, input ready);
  modport sink (input valid, current_position, req_delta, output ready);
endinterface

interface jslm_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [jslm_pkg::DataW-1:0]   allowed_delta;
  logic                                was_clamped;
  modport source (output valid, allowed_delta, was_clamped, input ready);
  modport sink (input valid, allowed_delta, was_clamped, output ready);
endinterface

[rtl/jslm_divider.sv]
module jslm_divider (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [jslm_pkg::SpdW-1:0]     divisor_i,
  input  logic [jslm_pkg::NumW-1:0]     dividend_i,
  output logic [jslm_pkg::NumW-1:0]     quotient_o
);
  import jslm_pkg::*;

  logic [SpdW-1:0] rem_q [NumW];
  logic [NumW-1:0] num_q [NumW];
  logic [SpdW-1:0] div_q [NumW];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [SpdW-1:0] rem_in;
    logic [SpdW-1:0] div_in;
    logic [NumW-1:0] num_in;
    logic [SpdW:0]   shf;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign div_in = divisor_i;
      assign num_in = dividend_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign div_in = div_q[k-1];
      assign num_in = num_q[k-1];
    end

    assign shf = {rem_in, num_in[NumW-1]};
    assign ge  = shf >= {1'b0, div_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? SpdW'(shf - {1'b0, div_in}) : shf[SpdW-1:0];
        num_q[k] <= {num_in[NumW-2:0], ge};
        div_q[k] <= div_in;
      end
    end
  end

  assign quotient_o = num_q[NumW-1];

endmodule

[rtl/joint_soft_limit_move_clamp.sv]
// Soft angle limit for one joint. Each transfer on in_i carries the current position and a
// requested delta in motor steps; one result per transfer leaves on out_o in order, with the
// delta cut back to the angle limit when the move would leave it and steps per degree is
// nonzero. A new item is taken every cycle unless out_o stalls. The item passes 42 register
// stages before its result is on out_o. Those stages are the two 35-stage restoring dividers
// (one quotient bit per stage) that turn steps into tenths of a degree, plus three stages in
// front for steps per degree and four behind for the clamp product, the divide by ten and the
// output register. A stall on out_o holds the whole pipeline. Registers are written through
// cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only while idle, which the
// block leaves unchecked.
module joint_soft_limit_move_clamp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jslm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [jslm_pkg::CfgW-1:0]     cfg_data_i,
  jslm_in_if.sink                       in_i,
  jslm_out_if.source                    out_o
);
  import jslm_pkg::*;

  typedef struct packed {
    logic                 neg_c;
    logic                 neg_d;
    logic                 zero;
    logic [SpdW-1:0]      spd;
    logic [DataW-1:0]     dlt;
  } side_t;

  logic [CfgW-1:0]        spr_q, gear_q;
  logic signed [CfgW-1:0] lmin_q, lmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q  <= StepsPerRevRst;
      gear_q <= GearRatioRst;
      lmin_q <= LimitMinRst;
      lmax_q <= LimitMaxRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStepsPerRev: spr_q  <= cfg_data_i;
        RegGearRatio:   gear_q <= cfg_data_i;
        RegLimitMin:    lmin_q <= cfg_data_i;
        RegLimitMax:    lmax_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // stage 0: gear product
  logic             s0_vld_q;
  logic [YW-1:0]    s0_y_q;
  logic [DataW-1:0] s0_cur_q, s0_dlt_q;
  logic [CfgW-1:0]  g_eff;
  logic [31:0]      gprod;

  assign g_eff = (gear_q == '0) ? GearDefault : gear_q;
  assign gprod = 32'(spr_q) * 32'(g_eff);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_y_q   <= gprod[31:5];
      s0_cur_q <= in_i.current_position;
      s0_dlt_q <= in_i.req_delta;
    end
  end

  // stage 1: reciprocal product, step magnitudes times ten
  logic             s1_vld_q;
  logic [YW-1:0]    s1_y_q;
  logic [SpdW-1:0]  s1_q0_q;
  logic [NumW-1:0]  s1_a_q, s1_b_q;
  logic             s1_neg_c_q, s1_neg_d_q;
  logic [DataW-1:0] s1_dlt_q;
  logic [54:0]      rprod;
  logic [DataW-1:0] mag_c, mag_d;

  assign rprod = 55'(s0_y_q) * 55'(SpdRecip);
  assign mag_c = s0_cur_q[DataW-1] ? DataW'(-s0_cur_q) : s0_cur_q;
  assign mag_d = s0_dlt_q[DataW-1] ? DataW'(-s0_dlt_q) : s0_dlt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_y_q     <= s0_y_q;
      s1_q0_q    <= rprod[SpdShift+SpdW-1:SpdShift];
      s1_a_q     <= {mag_c, 3'b000} + {2'b00, mag_c, 1'b0};
      s1_b_q     <= {mag_d, 3'b000} + {2'b00, mag_d, 1'b0};
      s1_neg_c_q <= s0_cur_q[DataW-1];
      s1_neg_d_q <= s0_dlt_q[DataW-1];
      s1_dlt_q   <= s0_dlt_q;
    end
  end

  // stage 2: steps per degree after correction
  logic             s2_vld_q;
  side_t            s2_q;
  logic [NumW-1:0]  s2_a_q, s2_b_q;
  logic [YW-1:0]    spd_rem;
  logic [SpdW-1:0]  spd;

  assign spd_rem = s1_y_q - YW'(28'(s1_q0_q) * 28'(SpdDivisor));
  assign spd     = s1_q0_q + SpdW'(spd_rem >= YW'(SpdDivisor));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.neg_c <= s1_neg_c_q;
      s2_q.neg_d <= s1_neg_d_q;
      s2_q.zero  <= (spd == '0);
      s2_q.spd   <= spd;
      s2_q.dlt   <= s1_dlt_q;
      s2_a_q     <= s1_a_q;
      s2_b_q     <= s1_b_q;
    end
  end

  // divider stages
  logic [NumW-1:0] side_vld_q;
  side_t           side_q [NumW];
  logic [NumW-1:0] qc, qd;

  jslm_divider u_div_cur (
    .clk_i      (clk_i),
    .en_i       (en),
    .divisor_i  (s2_q.spd),
    .dividend_i (s2_a_q),
    .quotient_o (qc)
  );

  jslm_divider u_div_dlt (
    .clk_i      (clk_i),
    .en_i       (en),
    .divisor_i  (s2_q.spd),
    .dividend_i (s2_b_q),
    .quotient_o (qd)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s2_q;
      for (int k = 1; k < NumW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // stage 3: limit check and distance to limit
  side_t                 sd;
  logic signed [QW-1:0]  cq, dq, dsum, lim, diff;
  logic                  pos, out_rng;

  assign sd      = side_q[NumW-1];
  assign cq      = sd.neg_c ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
  assign dq      = sd.neg_d ? -$signed({2'b00, qd}) : $signed({2'b00, qd});
  assign dsum    = cq + dq;
  assign out_rng = (dsum < QW'(lmin_q)) || (dsum > QW'(lmax_q));
  assign pos     = !sd.neg_d && (sd.dlt != '0);
  assign lim     = pos ? QW'(lmax_q) : QW'(lmin_q);
  assign diff    = lim - cq;

  logic             s3_vld_q, s3_zero_q, s3_out_q, s3_neg_q;
  logic [MagW-1:0]  s3_mag_q;
  logic [SpdW-1:0]  s3_spd_q;
  logic [DataW-1:0] s3_dlt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_zero_q <= sd.zero;
      s3_out_q  <= out_rng;
      s3_neg_q  <= diff[QW-1];
      s3_mag_q  <= diff[QW-1] ? MagW'(-diff) : diff[MagW-1:0];
      s3_spd_q  <= sd.spd;
      s3_dlt_q  <= sd.dlt;
    end
  end

  // stage 4: distance back to steps
  logic             s4_vld_q, s4_zero_q, s4_out_q, s4_neg_q;
  logic [ProdW-1:0] s4_m_q;
  logic [DataW-1:0] s4_dlt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_m_q    <= ProdW'(s3_mag_q) * ProdW'(s3_spd_q);
      s4_zero_q <= s3_zero_q;
      s4_out_q  <= s3_out_q;
      s4_neg_q  <= s3_neg_q;
      s4_dlt_q  <= s3_dlt_q;
    end
  end

  // stage 5: upper half divided by ten
  logic [HalfW-1:0] hi;
  logic [D10W-1:0]  qh_w;
  logic [D10W-1:0]  rh_w;

  assign hi   = s4_m_q[MagW-1:HalfW];
  assign qh_w = div10(D10W'(hi));
  assign rh_w = D10W'(hi) - D10W'(qh_w * D10W'(10));

  logic             s5_vld_q, s5_zero_q, s5_out_q, s5_neg_q, s5_big_q;
  logic [HalfW-1:0] s5_qh_q, s5_lo_q;
  logic [3:0]       s5_rh_q;
  logic [DataW-1:0] s5_dlt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_big_q  <= |s4_m_q[ProdW-1:MagW];
      s5_qh_q   <= qh_w[HalfW-1:0];
      s5_rh_q   <= rh_w[3:0];
      s5_lo_q   <= s4_m_q[HalfW-1:0];
      s5_zero_q <= s4_zero_q;
      s5_out_q  <= s4_out_q;
      s5_neg_q  <= s4_neg_q;
      s5_dlt_q  <= s4_dlt_q;
    end
  end

  // stage 6: lower half, saturation and output register
  logic [D10W-1:0]  ql_w;
  logic [MagW-1:0]  qmag;
  logic [DataW-1:0] clampv;
  logic             clamped;

  assign ql_w = div10({s5_rh_q, s5_lo_q});
  assign qmag = {s5_qh_q, {HalfW{1'b0}}} + MagW'(ql_w);

  always_comb begin
    if (!s5_neg_q) begin
      if (s5_big_q || (qmag > MagW'(36'h07FFFFFFF))) begin
        clampv = 32'h7FFFFFFF;
      end else begin
        clampv = qmag[DataW-1:0];
      end
    end else begin
      if (s5_big_q || (qmag > MagW'(36'h080000000))) begin
        clampv = 32'h80000000;
      end else begin
        clampv = DataW'(-qmag);
      end
    end
  end

  assign clamped = !s5_zero_q && s5_out_q;

  logic [DataW-1:0] allowed_q;
  logic             clamped_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      allowed_q <= clamped ? clampv : s5_dlt_q;
      clamped_q <= clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q   <= 1'b0;
      s1_vld_q   <= 1'b0;
      s2_vld_q   <= 1'b0;
      side_vld_q <= '0;
      s3_vld_q   <= 1'b0;
      s4_vld_q   <= 1'b0;
      s5_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      s0_vld_q   <= in_i.valid;
      s1_vld_q   <= s0_vld_q;
      s2_vld_q   <= s1_vld_q;
      side_vld_q <= {side_vld_q[NumW-2:0], s2_vld_q};
      s3_vld_q   <= side_vld_q[NumW-1];
      s4_vld_q   <= s3_vld_q;
      s5_vld_q   <= s4_vld_q;
      out_vld_q  <= s5_vld_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.allowed_delta = allowed_q;
  assign out_o.was_clamped   = clamped_q;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s0_vld_q)
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({s0_vld_q, s1_vld_q, s2_vld_q, side_vld_q, s3_vld_q, s4_vld_q,
                     s5_vld_q, out_vld_q}))
    else $error("pipeline valid bits moved during stall");

  a_spd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q |-> s2_q.spd <= SpdMax)
    else $error("steps per degree out of range");

  a_zero_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s5_vld_q && s5_zero_q && en |=> !out_o.was_clamped)
    else $error("clamp reported with zero steps per degree");

endmodule

[test/joint_soft_limit_move_clamp_tb.sv]
`timescale 1ns / 1ps

module joint_soft_limit_move_clamp_tb;
  import jslm_pkg::*;

  localparam int Latency  = 42;
  localparam int Watchdog = 20000;

  typedef struct packed {
    logic signed [DataW-1:0] allowed_delta;
    logic                    was_clamped;
  } move_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegStepsPerRev;
  logic [CfgW-1:0] cfg_data_i = '0;

  jslm_in_if  in_if ();
  jslm_out_if out_if ();

  joint_soft_limit_move_clamp i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if.sink),
    .out_o      (out_if.source)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [15:0] steps_per_rev_q;
  logic [15:0] gear_ratio_q;
  logic signed [15:0] limit_min_q;
  logic signed [15:0] limit_max_q;

  move_result_t clamp_expected_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic move_result_t predict_clamp(logic signed [31:0] pos, logic signed [31:0] dlt);
    move_result_t r;
    longint unsigned g;
    longint unsigned spd;
    longint pos_d10;
    longint dlt_d10;
    longint sum;
    longint lim;
    longint cut;
    g = (gear_ratio_q == 0) ? 100 : gear_ratio_q;
    spd = (longint'(steps_per_rev_q) * g) / 36000;
    r.allowed_delta = dlt;
    r.was_clamped = 1'b0;
    if (spd != 0) begin
      pos_d10 = (longint'(pos) * 10) / longint'(spd);
      dlt_d10 = (longint'(dlt) * 10) / longint'(spd);
      sum = pos_d10 + dlt_d10;
      if (sum < longint'(limit_min_q) || sum > longint'(limit_max_q)) begin
        lim = (dlt > 0) ? longint'(limit_max_q) : longint'(limit_min_q);
        cut = ((lim - pos_d10) * longint'(spd)) / 10;
        if (cut > 64'sd2147483647) cut = 64'sd2147483647;
        if (cut < -64'sd2147483648) cut = -64'sd2147483648;
        r.allowed_delta = cut[31:0];
        r.was_clamped = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegStepsPerRev: steps_per_rev_q = val;
      RegGearRatio:   gear_ratio_q = val;
      RegLimitMin:    limit_min_q = val;
      default:        limit_max_q = val;
    endcase
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (clamp_expected_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic configure(logic [15:0] spr, logic [15:0] gr, logic [15:0] lo, logic [15:0] hi);
    wait_drained();
    write_reg(RegStepsPerRev, spr);
    write_reg(RegGearRatio, gr);
    write_reg(RegLimitMin, lo);
    write_reg(RegLimitMax, hi);
  endtask

  task automatic send_move(logic signed [31:0] pos, logic signed [31:0] dlt, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.current_position <= pos;
    in_if.req_delta <= dlt;
    do @(posedge clk_i); while (!in_if.ready);
    clamp_expected_q.push_back(predict_clamp(pos, dlt));
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 4000) - 2000;
      2: return $urandom_range(0, 400000) - 200000;
      3: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
    endcase
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.current_position = '0;
    in_if.req_delta = '0;
    out_if.ready = 1'b0;
  end

  always begin
    int stall;
    stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (stall > 0) begin
      out_if.ready <= 1'b0;
      repeat (stall) @(negedge clk_i);
    end
    out_if.ready <= 1'b1;
    do @(posedge clk_i); while (!out_if.valid);
    @(negedge clk_i);
  end

  always @(posedge clk_i) begin
    move_result_t exp_r;
    if (rst_ni && (in_if.valid && in_if.ready || out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (clamp_expected_q.size() == 0) begin
        $display("%0t: unexpected result delta=%0d clamped=%0b", $time,
                 out_if.allowed_delta, out_if.was_clamped);
        errors++;
      end else begin
        exp_r = clamp_expected_q.pop_front();
        if (exp_r.allowed_delta !== out_if.allowed_delta) begin
          $display("%0t: allowed_delta expected %0d actual %0d", $time,
                   exp_r.allowed_delta, out_if.allowed_delta);
          errors++;
        end
        if (exp_r.was_clamped !== out_if.was_clamped) begin
          $display("%0t: was_clamped expected %0b actual %0b", $time,
                   exp_r.was_clamped, out_if.was_clamped);
          errors++;
        end
      end
    end
    if (idle_cycles >= Watchdog) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_reset_defaults();
    send_move(0, 0, 0);
    send_move(0, 32'sd100000, 0);
    send_move(0, -32'sd100000, 0);
    send_move(32'sh7fffffff, 32'sh7fffffff, 0);
    send_move(32'sh80000000, 32'sh80000000, 0);
    send_move(32'sh80000000, 32'sh7fffffff, 1);
    send_move(32'sh7fffffff, 32'sh80000000, 1);
    send_move(1600, 0, 1);
    send_move(-1600, 0, 1);
  endtask

  task automatic test_zero_spd();
    configure(16'd0, 16'd0, 16'h8000, 16'h7fff);
    send_move(32'sh7fffffff, 32'sh80000000, 0);
    send_move(12345, -999, 1);
    configure(16'd359, 16'd100, 16'd0, 16'd0);
    send_move(5, 1000000, 1);
  endtask

  task automatic test_extremes();
    configure(16'hffff, 16'hffff, 16'd0, 16'd0);
    send_move(32'sh80000000, 32'sh7fffffff, 0);
    send_move(32'sh7fffffff, 32'sh80000000, 0);
    send_move(32'sh7fffffff, 0, 1);
    configure(16'd360, 16'd100, 16'h8000, 16'h7fff);
    send_move(32'sh7fffffff, 32'sh7fffffff, 1);
    send_move(32'sh80000000, 32'sh80000000, 1);
    send_move(32'sh80000000, 1, 1);
  endtask

  task automatic test_inverted_limits();
    configure(16'd3200, 16'd0, 16'd500, 16'hfe0c);
    send_move(0, 0, 0);
    send_move(0, 32'sd2000, 1);
    send_move(0, -32'sd2000, 1);
  endtask

  task automatic test_random_moves();
    for (int phase = 0; phase < 6; phase++) begin
      configure(16'($urandom_range(0, 1) ? $urandom : $urandom_range(200, 60000)),
                $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom),
                16'($urandom_range(0, 1) ? $urandom : -$urandom_range(0, 3600)),
                16'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 3600)));
      for (int i = 0; i < 150; i++) begin
        send_move(rand_word(), rand_word(), i % 50 >= 20);
        if (i == 75 && phase == 2) wait_drained();
      end
    end
  endtask

  initial begin
    steps_per_rev_q = StepsPerRevRst;
    gear_ratio_q = GearRatioRst;
    limit_min_q = LimitMinRst;
    limit_max_q = LimitMaxRst;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_zero_spd();
    test_extremes();
    test_inverted_limits();
    test_random_moves();
    wait_drained();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
